### hdl/bds_pkg.sv
// Shared constants, types and helper functions for the 2x2 box downsampler.
// No dependencies; every other file of the block but bds_ram refers to this package.
package bds_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int DIM_W       = 13;
    localparam int CNT_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CMP_W       = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;
    localparam int HALF_DEPTH  = MAX_WIDTH / 2;
    localparam int SLOT_W      = $clog2(HALF_DEPTH);

    // Channel arithmetic.
    localparam int NCH         = 4;
    localparam int CH_RED      = 0;
    localparam int CH_GREEN    = 1;
    localparam int CH_BLUE     = 2;
    localparam int CH_ALPHA    = 3;
    localparam int PIX_W       = 8;
    localparam int PAIR_W      = PIX_W + 1;
    localparam int SUM_W       = PIX_W + 2;
    localparam int ROUND_ADD   = 2;
    localparam int LINE_W      = NCH * PAIR_W;

    // Task queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CMP_W-1:0] DIM_MIN  = CMP_W'(2);
    localparam logic [CMP_W-1:0] WIDTH_HI = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] HEIGHT_HI = CMP_W'(MAX_HEIGHT);

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             alpha_en;
    } t_cfg;

    // One unit of back-end work: either store a pair sum or emit a block.
    typedef struct packed {
        logic                          emit;
        logic [SLOT_W-1:0]             slot;
        logic [NCH-1:0][PAIR_W-1:0]    pair;
        logic                          last;
        logic                          alpha_en;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [CMP_W-1:0] hi);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext < DIM_MIN) return DIM_MIN;
        if (ext > hi) return hi;
        return ext;
    endfunction

endpackage

### hdl/bds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bds_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bds_front.sv
// Front end: accepts pixels, tracks the raster position and classifies each
// pixel into a line store write, a block emit or nothing. Uses bds_pkg.
module bds_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bds_pkg::t_cfg           i_cfg,
    input  logic                    i_valid,
    input  logic [bds_pkg::PIX_W-1:0] i_red_in,
    input  logic [bds_pkg::PIX_W-1:0] i_green_in,
    input  logic [bds_pkg::PIX_W-1:0] i_blue_in,
    input  logic [bds_pkg::PIX_W-1:0] i_alpha_in,
    output logic                    o_stall,
    input  bds_pkg::t_q_stat        i_q_stat,
    output logic                    o_push,
    output bds_pkg::t_task          o_task
);

    logic [bds_pkg::CNT_W-1:0] r_col, n_col;
    logic [bds_pkg::ROW_W-1:0] r_row, n_row;
    logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0] r_acc;
    logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0] px;

    logic [bds_pkg::CMP_W-1:0] w, h, col_x, row_x;
    logic accept, pair_ok, op_write, op_emit, last;

    always_comb begin
        w     = bds_pkg::clamp_dim(i_cfg.width, bds_pkg::WIDTH_HI);
        h     = bds_pkg::clamp_dim(i_cfg.height, bds_pkg::HEIGHT_HI);
        col_x = bds_pkg::CMP_W'(r_col);
        row_x = bds_pkg::CMP_W'(r_row);

        px[bds_pkg::CH_RED]   = i_red_in;
        px[bds_pkg::CH_GREEN] = i_green_in;
        px[bds_pkg::CH_BLUE]  = i_blue_in;
        px[bds_pkg::CH_ALPHA] = i_cfg.alpha_en ? i_alpha_in : '0;

        // A pair completes on an odd column that is not the dropped odd last one.
        pair_ok  = r_col[0] && (col_x < {w[bds_pkg::CMP_W-1:1], 1'b0});
        op_write = pair_ok && !r_row[0];
        op_emit  = pair_ok && r_row[0] && (row_x < {h[bds_pkg::CMP_W-1:1], 1'b0});
        last     = ((col_x >> 1) == ((w >> 1) - bds_pkg::CMP_W'(1)))
                && ((row_x >> 1) == ((h >> 1) - bds_pkg::CMP_W'(1)));

        accept = i_valid && !i_q_stat.full;

        if (col_x >= w - bds_pkg::CMP_W'(1)) begin
            n_col = '0;
            n_row = (row_x >= h - bds_pkg::CMP_W'(1)) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end

        o_task.emit     = op_emit;
        o_task.slot     = r_col[bds_pkg::CNT_W-1:1];
        o_task.last     = last;
        o_task.alpha_en = i_cfg.alpha_en;
        for (int c = 0; c < bds_pkg::NCH; c++) begin
            o_task.pair[c] = {1'b0, r_acc[c]} + {1'b0, px[c]};
        end
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = accept && (op_write || op_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_col[0]) begin
            r_acc <= px;
        end
    end

endmodule

### hdl/bds_queue.sv
// Short task queue between the front end and the back end.
// Uses bds_pkg for the task type and depth.
module bds_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bds_pkg::t_task    i_task,
    input  logic              i_pop,
    output bds_pkg::t_q_stat  o_stat,
    output bds_pkg::t_task    o_head
);

    bds_pkg::t_task r_mem [bds_pkg::QUEUE_DEPTH];
    logic [bds_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [bds_pkg::QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    assign o_stat.full  = (r_count == bds_pkg::QCNT_W'(bds_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

endmodule

### hdl/bds_back.sv
// Back end: carries out queued tasks against the half-row line store and
// forms the rounded block means in an output register. Uses bds_pkg, bds_ram.
module bds_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bds_pkg::t_q_stat          i_q_stat,
    input  bds_pkg::t_task            i_head,
    output logic                      o_pop,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [bds_pkg::PIX_W-1:0] o_red_out,
    output logic [bds_pkg::PIX_W-1:0] o_green_out,
    output logic [bds_pkg::PIX_W-1:0] o_blue_out,
    output logic [bds_pkg::PIX_W-1:0] o_alpha_out,
    output logic                      o_frame_last
);

    // Read stage: line store data arrives in the cycle after the read.
    logic                                      r_b_valid;
    logic [bds_pkg::NCH-1:0][bds_pkg::PAIR_W-1:0] r_b_pair;
    logic                                      r_b_last;
    logic                                      r_b_alpha_en;

    // Output register.
    logic                                      r_o_valid;
    logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0]  r_o_pix;
    logic                                      r_o_last;

    logic [bds_pkg::LINE_W-1:0]                rdata;
    logic [bds_pkg::NCH-1:0][bds_pkg::PAIR_W-1:0] above;
    logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0]  mean;
    logic [bds_pkg::SUM_W-1:0]                 sum;
    logic out_load, b_adv, ram_we, ram_re;

    always_comb begin
        out_load = r_b_valid && (!r_o_valid || !i_stall);
        b_adv    = !r_b_valid || out_load;
        o_pop    = !i_q_stat.empty && (!i_head.emit || b_adv);
        ram_we   = o_pop && !i_head.emit;
        ram_re   = o_pop && i_head.emit;
        above    = rdata;
        for (int c = 0; c < bds_pkg::NCH; c++) begin
            sum = bds_pkg::SUM_W'(above[c]) + bds_pkg::SUM_W'(r_b_pair[c])
                + bds_pkg::SUM_W'(bds_pkg::ROUND_ADD);
            mean[c] = sum[bds_pkg::SUM_W-1:2];
        end
        if (!r_b_alpha_en) begin
            mean[bds_pkg::CH_ALPHA] = '0;
        end
    end

    bds_ram #(
        .WIDTH(bds_pkg::LINE_W),
        .DEPTH(bds_pkg::HALF_DEPTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_head.slot),
        .i_wdata(i_head.pair),
        .i_re   (ram_re),
        .i_raddr(i_head.slot),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_adv) begin
                r_b_valid <= ram_re;
            end
            if (!r_o_valid || !i_stall) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_b_pair     <= i_head.pair;
            r_b_last     <= i_head.last;
            r_b_alpha_en <= i_head.alpha_en;
        end
        if (out_load) begin
            r_o_pix  <= mean;
            r_o_last <= r_b_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_red_out    = r_o_pix[bds_pkg::CH_RED];
    assign o_green_out  = r_o_pix[bds_pkg::CH_GREEN];
    assign o_blue_out   = r_o_pix[bds_pkg::CH_BLUE];
    assign o_alpha_out  = r_o_pix[bds_pkg::CH_ALPHA];
    assign o_frame_last = r_o_last;

endmodule

### hdl/box_downsample_2x2_top.sv
// Top level of the 2x2 box-filter downsampler: configuration registers,
// front end, task queue and back end. Uses bds_pkg, bds_front, bds_queue, bds_back.
//
// Pixels enter in raster order on i_valid / o_stall, one port per channel, and
// an item is taken at a rising edge where i_valid is high and o_stall is low.
// For each complete 2x2 block one pixel leaves on o_valid / i_stall with the
// mean of each channel, (sum + 2) / 4, and o_frame_last on the last block of
// the frame. An odd last column or row is consumed and gives no output.
// Width, height and alpha enable are written on i_cfg_valid / o_cfg_ready,
// which is always ready; write them only while the block is idle.
// Throughput is one pixel per cycle while o_stall is low. A block result passes
// through the task queue, the line store read and the output register before
// it shows on o_valid.
// When the receiver stalls, the output register holds its item, the back end
// stops issuing reads and the four-entry task queue fills; o_stall rises once
// that queue is full and then holds every pixel, whether it makes a task or not.
// Reset (synchronous, active low) empties the pipeline, zeroes the raster
// position and restores 640 x 480 with alpha enabled; the line store needs no
// clearing pass.
module box_downsample_2x2_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bds_pkg::PIX_W-1:0]     i_red_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_green_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_blue_in,
    input  logic [bds_pkg::PIX_W-1:0]     i_alpha_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bds_pkg::PIX_W-1:0]     o_red_out,
    output logic [bds_pkg::PIX_W-1:0]     o_green_out,
    output logic [bds_pkg::PIX_W-1:0]     o_blue_out,
    output logic [bds_pkg::PIX_W-1:0]     o_alpha_out,
    output logic                          o_frame_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bds_pkg::DIM_W-1:0]     i_cfg_data
);

    bds_pkg::t_cfg    r_cfg;
    bds_pkg::t_q_stat q_stat;
    bds_pkg::t_task   push_task;
    bds_pkg::t_task   head_task;
    logic             q_push;
    logic             q_pop;

    // The register file takes a write in any cycle; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= bds_pkg::WIDTH_RESET;
            r_cfg.height   <= bds_pkg::HEIGHT_RESET;
            r_cfg.alpha_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bds_pkg::REG_WIDTH:  r_cfg.width    <= i_cfg_data;
                bds_pkg::REG_HEIGHT: r_cfg.height   <= i_cfg_data;
                bds_pkg::REG_ALPHA:  r_cfg.alpha_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_red_in  (i_red_in),
        .i_green_in(i_green_in),
        .i_blue_in (i_blue_in),
        .i_alpha_in(i_alpha_in),
        .o_stall   (o_stall),
        .i_q_stat  (q_stat),
        .o_push    (q_push),
        .o_task    (push_task)
    );

    bds_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_task (push_task),
        .i_pop  (q_pop),
        .o_stat (q_stat),
        .o_head (head_task)
    );

    bds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head_task),
        .o_pop       (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out),
        .o_frame_last(o_frame_last)
    );

    // The front end never pushes a task into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("task pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("task popped from an empty queue");

    // Reset leaves the queue empty and the output idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (q_stat.empty && !o_valid))
        else $error("pipeline not idle after reset");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_downsample_2x2_top: directed blocks, then random frames.
// Depends on bds_pkg and the RTL of the block; prediction is done locally in this file.
module testbench;

    // One input pixel and one averaged output block, laid out in port order.
    typedef struct packed {
        logic [bds_pkg::PIX_W-1:0] red;
        logic [bds_pkg::PIX_W-1:0] green;
        logic [bds_pkg::PIX_W-1:0] blue;
        logic [bds_pkg::PIX_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [bds_pkg::PIX_W-1:0] red;
        logic [bds_pkg::PIX_W-1:0] green;
        logic [bds_pkg::PIX_W-1:0] blue;
        logic [bds_pkg::PIX_W-1:0] alpha;
        logic                      last;
    } t_block;

    // A row of the directed plan is either a register write or a pixel. Pixel
    // rows whose result is obvious carry that result typed in by hand.
    typedef struct packed {
        logic                          is_reg;
        logic [bds_pkg::CFG_IDX_W-1:0] idx;
        logic [bds_pkg::DIM_W-1:0]     data;
        t_pixel                        px;
        logic                          typed;
        t_block                        want;
    } t_plan_row;

    // The receiver switches between these stall patterns every stretch.
    typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    localparam int SETTLE_CYCLES = 10;   // lets the pipeline drain after the last owed block
    localparam int SMALL_ITEMS   = 1375;
    localparam int REPORT_LIMIT  = 10;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [bds_pkg::PIX_W-1:0]     i_red_in;
    logic [bds_pkg::PIX_W-1:0]     i_green_in;
    logic [bds_pkg::PIX_W-1:0]     i_blue_in;
    logic [bds_pkg::PIX_W-1:0]     i_alpha_in;
    logic                          o_valid;
    logic                          i_stall;
    logic [bds_pkg::PIX_W-1:0]     o_red_out;
    logic [bds_pkg::PIX_W-1:0]     o_green_out;
    logic [bds_pkg::PIX_W-1:0]     o_blue_out;
    logic [bds_pkg::PIX_W-1:0]     o_alpha_out;
    logic                          o_frame_last;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [bds_pkg::DIM_W-1:0]     i_cfg_data;

    box_downsample_2x2_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Local copy of the configuration and the raster state of the block.
    logic [bds_pkg::DIM_W-1:0]  cfg_width  = bds_pkg::WIDTH_RESET;
    logic [bds_pkg::DIM_W-1:0]  cfg_height = bds_pkg::HEIGHT_RESET;
    logic                       cfg_alpha  = 1'b1;
    int unsigned                col_pos    = 0;
    int unsigned                row_pos    = 0;
    logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0]  held_pixel = '0;
    logic [bds_pkg::NCH-1:0][bds_pkg::PAIR_W-1:0] pair_sums [bds_pkg::HALF_DEPTH];

    t_block    blocks_due[$];   // averaged blocks still owed by the block
    t_plan_row plan[$];
    int        fail_count  = 0;
    int        blocks_seen = 0;
    int        fed_count   = 0;   // pixels accepted so far
    int        feed_left   = 0;   // pixels still to go in the current phase
    int        burst_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The run must be over long before this; hitting it means the block hung.
    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Width and height are clamped to the legal range before use.
    function automatic int dim_used(input logic [bds_pkg::DIM_W-1:0] raw, input int hi);
        if (raw < 2) return 2;
        if (int'(raw) > hi) return hi;
        return int'(raw);
    endfunction

    // Advances the raster position by one pixel. Even columns are parked; the
    // odd column closes a horizontal pair. On an even row the pair sum goes to
    // the half-row store, on an odd row it is combined with the stored sum from
    // the row above and one rounded block mean comes out. An odd trailing
    // column or row falls outside (w & ~1) / (h & ~1) and gives nothing.
    function automatic bit predict_block(input t_pixel p, output t_block b);
        int                                           w;
        int                                           h;
        int unsigned                                  slot;
        logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0]  ch;
        logic [bds_pkg::NCH-1:0][bds_pkg::PAIR_W-1:0] pair;
        logic [bds_pkg::NCH-1:0][bds_pkg::PIX_W-1:0]  mean;
        logic [bds_pkg::SUM_W-1:0]                    total;
        bit                                           made;
        w = dim_used(cfg_width, bds_pkg::MAX_WIDTH);
        h = dim_used(cfg_height, bds_pkg::MAX_HEIGHT);
        ch = {cfg_alpha ? p.alpha : 8'd0, p.blue, p.green, p.red};
        made = 1'b0;
        b = '0;
        if (col_pos[0] == 1'b0) begin
            held_pixel = ch;
        end else if (col_pos < unsigned'(w & ~1)) begin
            slot = col_pos >> 1;
            for (int c = 0; c < bds_pkg::NCH; c++) begin
                pair[c] = bds_pkg::PAIR_W'(held_pixel[c]) + bds_pkg::PAIR_W'(ch[c]);
            end
            if (row_pos[0] == 1'b0) begin
                pair_sums[slot] = pair;
            end else if (row_pos < unsigned'(h & ~1)) begin
                for (int c = 0; c < bds_pkg::NCH; c++) begin
                    total = bds_pkg::SUM_W'(pair_sums[slot][c]) + bds_pkg::SUM_W'(pair[c])
                          + bds_pkg::SUM_W'(bds_pkg::ROUND_ADD);
                    mean[c] = total[bds_pkg::SUM_W-1:2];
                end
                b.red   = mean[bds_pkg::CH_RED];
                b.green = mean[bds_pkg::CH_GREEN];
                b.blue  = mean[bds_pkg::CH_BLUE];
                b.alpha = cfg_alpha ? mean[bds_pkg::CH_ALPHA] : 8'd0;
                b.last  = (slot == unsigned'(w / 2 - 1))
                       && ((row_pos >> 1) == unsigned'(h / 2 - 1));
                made = 1'b1;
            end
        end
        if (col_pos >= unsigned'(w - 1)) begin
            col_pos = 0;
            row_pos = (row_pos >= unsigned'(h - 1)) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return made;
    endfunction

    function automatic t_plan_row px_row(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] bl, input logic [7:0] a);
        t_plan_row row;
        row = '0;
        row.px = {r, g, bl, a};
        return row;
    endfunction

    function automatic t_plan_row px_known(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] bl, input logic [7:0] a,
                                           input t_block want);
        t_plan_row row;
        row = px_row(r, g, bl, a);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_plan_row reg_row(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [bds_pkg::DIM_W-1:0] data);
        t_plan_row row;
        row = '0;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // Channel levels lean toward the two rails so rounding at the top and
    // bottom of the range gets exercised often.
    function automatic logic [7:0] any_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pixel any_pixel();
        return {any_level(), any_level(), any_level(), any_level()};
    endfunction

    // Writes one register and mirrors it in the local configuration. The
    // block is idle whenever this is called.
    task automatic write_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bds_pkg::DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
            @(posedge i_clk);
        end
        case (idx)
            bds_pkg::REG_WIDTH:  cfg_width  = data;
            bds_pkg::REG_HEIGHT: cfg_height = data;
            bds_pkg::REG_ALPHA:  cfg_alpha  = data[0];
            default:    ;
        endcase
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one pixel. The sender runs in bursts; at the start of each burst
    // it may drop valid for a random gap. Acceptance is decided from o_stall
    // as it stands at the falling edge, which is what the next rising edge
    // sees, so the prediction is made before any result can show up.
    task automatic feed_pixel(input t_pixel p, input bit typed, input t_block want);
        int     gap;
        t_block b;
        bit     made;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_red_in   <= p.red;
        i_green_in <= p.green;
        i_blue_in  <= p.blue;
        i_alpha_in <= p.alpha;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
            @(posedge i_clk);
        end
        made = predict_block(p, b);
        if (typed) blocks_due.push_back(want);
        else if (made) blocks_due.push_back(b);
        fed_count++;
        if (feed_left > 0) feed_left--;
        @(posedge i_clk);
    endtask

    // Stops offering pixels and waits until every owed block has come out,
    // then lets the pipeline drain pixels that owe nothing.
    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random phase: new frame geometry and alpha mode, then a number of
    // random pixels that is normally a whole number of frames.
    task automatic run_phase(input logic [bds_pkg::DIM_W-1:0] w_raw,
                             input logic [bds_pkg::DIM_W-1:0] h_raw,
                             input logic [bds_pkg::DIM_W-1:0] alpha_raw, input int pixels);
        wait_idle();
        write_reg(bds_pkg::REG_WIDTH, w_raw);
        write_reg(bds_pkg::REG_HEIGHT, h_raw);
        write_reg(bds_pkg::REG_ALPHA, alpha_raw);
        feed_left = pixels;
        repeat (pixels) feed_pixel(any_pixel(), 1'b0, '0);
    endtask

    // Receiver. It changes stall pattern every stretch of cycles, and from
    // time to time holds off completely for a long stretch while the sender
    // is in the middle of a phase, so the task queue fills and o_stall rises.
    initial begin : receiver
        t_rx_mode mode;
        int       stretch;
        int       hold_left;
        int       hold_mark;
        mode      = RX_FLOW;
        stretch   = 0;
        hold_left = 0;
        hold_mark = 300;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && fed_count >= hold_mark && feed_left >= 64) begin
                hold_left = 300;
                hold_mark = hold_mark + 900;
            end
            if (stretch == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                stretch = $urandom_range(10, 80);
            end
            stretch--;
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FLOW:   i_stall <= 1'b0;
                    RX_LIGHT:  i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
                    RX_TOGGLE: i_stall <= ~i_stall;
                    default:   i_stall <= 1'b0;
                endcase
            end
        end
    end

    // Output checker. Sampled at the falling edge: a block seen valid and not
    // stalled here is the one taken at the next rising edge.
    always @(negedge i_clk) begin : collect
        t_block got;
        t_block want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_red_out, o_green_out, o_blue_out, o_alpha_out, o_frame_last};
            blocks_seen++;
            if (blocks_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: block with nothing owed: r=%0d g=%0d b=%0d a=%0d last=%0b",
                             $realtime, got.red, got.green, got.blue, got.alpha, got.last);
            end else begin
                want = blocks_due.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha ||
                    got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: block %0d want %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                                 $realtime, blocks_seen, want.red, want.green, want.blue,
                                 want.alpha, want.last, got.red, got.green, got.blue,
                                 got.alpha, got.last);
                end
            end
        end
    end

    // Main sequence: reset, directed plan, random phases, drain and verdict.
    initial begin : stimulus
        int                        small_fed;
        int                        frames;
        int                        frame_px;
        logic [bds_pkg::DIM_W-1:0] w_raw;
        logic [bds_pkg::DIM_W-1:0] h_raw;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_red_in    <= '0;
        i_green_in  <= '0;
        i_blue_in   <= '0;
        i_alpha_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bds_pkg::REG_WIDTH;
        i_cfg_data  <= '0;

        // Directed plan. The frame is shrunk to a single 2x2 block; alpha is
        // left at its reset value so the first blocks also show that alpha is
        // averaged out of reset.
        plan.push_back(reg_row(bds_pkg::REG_WIDTH, 13'd2));
        plan.push_back(reg_row(bds_pkg::REG_HEIGHT, 13'd2));
        // All channels at full scale: the mean stays at full scale.
        repeat (3) plan.push_back(px_row(8'd255, 8'd255, 8'd255, 8'd255));
        plan.push_back(px_known(8'd255, 8'd255, 8'd255, 8'd255,
                                {8'd255, 8'd255, 8'd255, 8'd255, 1'b1}));
        // All channels at zero.
        repeat (3) plan.push_back(px_row(8'd0, 8'd0, 8'd0, 8'd0));
        plan.push_back(px_known(8'd0, 8'd0, 8'd0, 8'd0, {8'd0, 8'd0, 8'd0, 8'd0, 1'b1}));
        // Rounding on each side of the half step, per channel.
        plan.push_back(px_row(8'd1, 8'd1, 8'd255, 8'd255));
        plan.push_back(px_row(8'd1, 8'd0, 8'd255, 8'd0));
        plan.push_back(px_row(8'd0, 8'd0, 8'd255, 8'd0));
        plan.push_back(px_row(8'd0, 8'd0, 8'd254, 8'd0));
        // Alpha disabled, written with the upper data bits set: only bit 0
        // counts, and alpha comes out as zero whatever goes in.
        plan.push_back(reg_row(bds_pkg::REG_ALPHA, 13'h1FFE));
        repeat (3) plan.push_back(px_row(8'd200, 8'd100, 8'd50, 8'd255));
        plan.push_back(px_known(8'd200, 8'd100, 8'd50, 8'd255,
                                {8'd200, 8'd100, 8'd50, 8'd0, 1'b1}));
        // A 3x3 frame: the odd last column and odd last row are consumed
        // silently and the single block is the last of the frame.
        plan.push_back(reg_row(bds_pkg::REG_WIDTH, 13'd3));
        plan.push_back(reg_row(bds_pkg::REG_HEIGHT, 13'd3));
        plan.push_back(reg_row(bds_pkg::REG_ALPHA, 13'd1));
        plan.push_back(px_row(8'd12, 8'd250, 8'd7, 8'd128));
        plan.push_back(px_row(8'd34, 8'd3, 8'd99, 8'd1));
        plan.push_back(px_row(8'd200, 8'd200, 8'd200, 8'd200));
        plan.push_back(px_row(8'd56, 8'd77, 8'd88, 8'd99));
        plan.push_back(px_row(8'd255, 8'd0, 8'd128, 8'd64));
        plan.push_back(px_row(8'd1, 8'd2, 8'd3, 8'd4));
        plan.push_back(px_row(8'd9, 8'd9, 8'd9, 8'd9));
        plan.push_back(px_row(8'd8, 8'd8, 8'd8, 8'd8));
        plan.push_back(px_row(8'd7, 8'd7, 8'd7, 8'd7));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                if (k == 0 || !plan[k-1].is_reg) wait_idle();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                feed_pixel(plan[k].px, plan[k].typed, plan[k].want);
            end
        end

        // Random phases of whole frames. Most frames are small; out-of-range
        // dimensions are mixed in to hit the clamping at the low end. The
        // frame count is trimmed so the pixel budget is not overrun.
        small_fed = 0;
        while (SMALL_ITEMS - small_fed >= 4) begin
            case ($urandom_range(0, 9))
                0:       w_raw = 13'($urandom_range(0, 1));
                1:       w_raw = 13'($urandom_range(13, 40));
                default: w_raw = 13'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       h_raw = 13'($urandom_range(0, 1));
                1:       h_raw = 13'($urandom_range(11, 24));
                default: h_raw = 13'($urandom_range(2, 10));
            endcase
            frame_px = dim_used(w_raw, bds_pkg::MAX_WIDTH)
                     * dim_used(h_raw, bds_pkg::MAX_HEIGHT);
            frames = $urandom_range(1, 4);
            if (small_fed + frames * frame_px > SMALL_ITEMS)
                frames = (SMALL_ITEMS - small_fed) / frame_px;
            if (frames != 0) begin
                run_phase(w_raw, h_raw, 13'($urandom), frames * frame_px);
                small_fed += frames * frame_px;
            end
        end

        // Tallest setting, clamped from above, with the narrowest row. This
        // frame is left unfinished: only the first few hundred rows are sent.
        run_phase(13'd1, 13'h1FFF, 13'h1FFF, 400);

        wait_idle();
        if (fail_count == 0 && blocks_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
